FILE: rtl/ibps_pkg.sv
// Shared types and constants for the infrared byte to pulse/space FIFO.
// Holds the request codes, the command passed from front to back end and
// the back end state encoding. Depends on nothing.
package ibps_pkg;

    // Request codes on the input channel
    typedef enum logic [1:0] {
        REQ_BYTE = 2'd0,
        REQ_TICK = 2'd1,
        REQ_POP  = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    // Special received byte values and duration rounding
    localparam logic [7:0] BYTE_SKIP = 8'd0;
    localparam logic [7:0] BYTE_END  = 8'd255;
    localparam logic [7:0] DUR_ROUND = 8'd128;

    // Gap offset register
    localparam int          OFFSET_W          = 24;
    localparam logic [23:0] GAP_OFFSET_RESET  = 24'd100000;

    // Width of the duration field on the result port
    localparam int OUT_DUR_W = 24;

    // Work handed to the back end
    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_NOP  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic      has_space;
        logic      signal_end;
    } cmd_ctrl_t;

    // Back end sequencer
    typedef enum logic [1:0] {
        BK_RUN      = 2'd0,
        BK_DATA     = 2'd1,
        BK_POP_WAIT = 2'd2
    } back_state_t;

endpackage

FILE: rtl/ibps_ram.sv
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
module ibps_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, hold data when not reading
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/ibps_front.sv
// Front end: classifies accepted requests, keeps the gap timer, phase and
// gap offset register, and builds the words to be stored.
// Depends on ibps_pkg.
module ibps_front #(
    parameter int DURATION_BITS = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [1:0]                  req_type,
    input  logic [7:0]                  rx_byte,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [23:0]                 cfg_data,
    output ibps_pkg::cmd_ctrl_t         cmd_ctrl,
    output logic [DURATION_BITS:0]      cmd_space,
    output logic [DURATION_BITS:0]      cmd_data
);

    import ibps_pkg::*;

    localparam int SUM_W = ((DURATION_BITS > OFFSET_W) ? DURATION_BITS : OFFSET_W) + 1;

    logic [DURATION_BITS-1:0] gap_reg, gap_next;
    logic                     phase_reg, phase_next;
    logic                     await_reg, await_next;
    logic [OFFSET_W-1:0]      offset_reg, offset_next;

    req_t                     req;
    logic [SUM_W-1:0]         gap_sum;
    logic [DURATION_BITS-1:0] space_dur;
    logic [DURATION_BITS-1:0] byte_dur;

    assign req       = req_t'(req_type);
    assign cfg_ready = 1'b1;

    // Saturated gap space and byte duration
    assign gap_sum   = SUM_W'(gap_reg) + SUM_W'(offset_reg);
    assign space_dur = (gap_sum > SUM_W'({DURATION_BITS{1'b1}})) ?
                       {DURATION_BITS{1'b1}} : gap_sum[DURATION_BITS-1:0];
    assign byte_dur  = DURATION_BITS'({rx_byte, DUR_ROUND});

    assign cmd_space = {1'b0, space_dur};
    assign cmd_data  = {phase_reg, byte_dur};

    // Classify the request and update signal state
    always_comb
    begin
        gap_next    = gap_reg;
        phase_next  = phase_reg;
        await_next  = await_reg;
        offset_next = offset_reg;
        cmd_ctrl    = '{kind: CMD_NOP, has_space: 1'b0, signal_end: 1'b0};

        unique case (req)
            REQ_BYTE:
            begin
                if (rx_byte == BYTE_END)
                begin
                    cmd_ctrl.signal_end = 1'b1;
                    if (accept)
                    begin
                        phase_next = 1'b1;
                        await_next = 1'b1;
                        gap_next   = '0;
                    end
                end
                else if (rx_byte != BYTE_SKIP)
                begin
                    cmd_ctrl.kind      = CMD_PUSH;
                    cmd_ctrl.has_space = await_reg;
                    if (accept)
                    begin
                        phase_next = ~phase_reg;
                        await_next = 1'b0;
                        if (await_reg)
                        begin
                            gap_next = '0;
                        end
                    end
                end
            end
            REQ_TICK:
            begin
                if (accept && (gap_reg != {DURATION_BITS{1'b1}}))
                begin
                    gap_next = gap_reg + 1'b1;
                end
            end
            REQ_POP:
            begin
                cmd_ctrl.kind = CMD_POP;
            end
            REQ_NONE:
            begin
                cmd_ctrl.kind = CMD_NOP;
            end
        endcase

        // Configuration write
        if (cfg_valid && cfg_ready)
        begin
            offset_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg    <= '0;
            phase_reg  <= 1'b1;
            await_reg  <= 1'b1;
            offset_reg <= GAP_OFFSET_RESET;
        end
        else
        begin
            gap_reg    <= gap_next;
            phase_reg  <= phase_next;
            await_reg  <= await_next;
            offset_reg <= offset_next;
        end
    end

endmodule

FILE: rtl/ibps_cmd_q.sv
// Two-entry command queue between the front end and the back end.
// Depends on ibps_pkg.
module ibps_cmd_q #(
    parameter int WORD_W = 25
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ibps_pkg::cmd_ctrl_t push_ctrl,
    input  logic [WORD_W-1:0]   push_space,
    input  logic [WORD_W-1:0]   push_data,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output ibps_pkg::cmd_ctrl_t head_ctrl,
    output logic [WORD_W-1:0]   head_space,
    output logic [WORD_W-1:0]   head_data
);

    import ibps_pkg::*;

    localparam int QD    = 2;
    localparam int IDX_W = $clog2(QD);
    localparam int CNT_W = $clog2(QD + 1);

    cmd_ctrl_t         ctrl_reg  [QD];
    logic [WORD_W-1:0] space_reg [QD];
    logic [WORD_W-1:0] data_reg  [QD];

    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (cnt_reg == CNT_W'(QD));
    assign head_valid = (cnt_reg != '0);
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    assign head_ctrl  = ctrl_reg[rd_idx_reg];
    assign head_space = space_reg[rd_idx_reg];
    assign head_data  = data_reg[rd_idx_reg];

    // Advance indexes and occupancy
    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_idx_next = (wr_idx_reg == IDX_W'(QD - 1)) ? '0 : wr_idx_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_idx_next = (rd_idx_reg == IDX_W'(QD - 1)) ? '0 : rd_idx_reg + 1'b1;
        end
        priority if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ctrl_reg[wr_idx_reg]  <= push_ctrl;
            space_reg[wr_idx_reg] <= push_space;
            data_reg[wr_idx_reg]  <= push_data;
        end
    end

endmodule

FILE: rtl/ibps_back.sv
// Back end: carries out queued commands against the word FIFO (RAM plus
// pointers and count) and drives the registered result channel.
// Depends on ibps_pkg and ibps_ram.
module ibps_back #(
    parameter int FIFO_DEPTH    = 256,
    parameter int DURATION_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  ibps_pkg::cmd_ctrl_t           q_ctrl,
    input  logic [DURATION_BITS:0]        q_space,
    input  logic [DURATION_BITS:0]        q_data,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          word_valid,
    output logic                          is_pulse,
    output logic [ibps_pkg::OUT_DUR_W-1:0] duration_us,
    output logic                          fifo_empty,
    output logic                          overflow_seen,
    output logic                          signal_end
);

    import ibps_pkg::*;

    localparam int WORD_W = DURATION_BITS + 1;
    localparam int PTR_W  = $clog2(FIFO_DEPTH);
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

    back_state_t      state_reg, state_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             dropped_reg, dropped_next;
    logic             out_valid_reg, out_valid_next;

    logic                 out_word_valid_reg, out_word_valid_next;
    logic                 out_pulse_reg, out_pulse_next;
    logic [OUT_DUR_W-1:0] out_dur_reg, out_dur_next;
    logic                 out_empty_reg, out_empty_next;
    logic                 out_overflow_reg, out_overflow_next;
    logic                 out_end_reg, out_end_next;

    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [WORD_W-1:0] ram_rd_data;
    logic              wr_req;
    logic [WORD_W-1:0] wr_word;
    logic              emit;
    logic              emit_valid;
    logic              emit_end;
    logic [WORD_W-1:0] emit_word;
    logic              out_free;

    function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    ibps_ram #(
        .WIDTH (WORD_W),
        .DEPTH (FIFO_DEPTH)
    ) u_word_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (wr_word),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rd_data)
    );

    // Sequence commands, update the FIFO and build the result
    always_comb
    begin
        state_next          = state_reg;
        rd_ptr_next         = rd_ptr_reg;
        wr_ptr_next         = wr_ptr_reg;
        count_next          = count_reg;
        dropped_next        = dropped_reg;
        out_valid_next      = out_valid_reg;
        out_word_valid_next = out_word_valid_reg;
        out_pulse_next      = out_pulse_reg;
        out_dur_next        = out_dur_reg;
        out_empty_next      = out_empty_reg;
        out_overflow_next   = out_overflow_reg;
        out_end_next        = out_end_reg;
        ram_wr_en           = 1'b0;
        ram_rd_en           = 1'b0;
        wr_req              = 1'b0;
        wr_word             = q_data;
        q_pop               = 1'b0;
        emit                = 1'b0;
        emit_valid          = 1'b0;
        emit_end            = 1'b0;
        emit_word           = ram_rd_data;

        out_free = !out_valid_reg || !out_stall;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            BK_RUN:
            begin
                if (q_valid && out_free)
                begin
                    unique case (q_ctrl.kind)
                        CMD_PUSH:
                        begin
                            wr_req = 1'b1;
                            if (q_ctrl.has_space)
                            begin
                                // Store the gap space first, then the data word in BK_DATA
                                wr_word    = q_space;
                                state_next = BK_DATA;
                            end
                            else
                            begin
                                emit  = 1'b1;
                                q_pop = 1'b1;
                            end
                        end
                        CMD_POP:
                        begin
                            q_pop = 1'b1;
                            if (count_reg != '0)
                            begin
                                ram_rd_en   = 1'b1;
                                rd_ptr_next = ptr_advance(rd_ptr_reg);
                                count_next  = count_reg - 1'b1;
                                state_next  = BK_POP_WAIT;
                            end
                            else
                            begin
                                emit = 1'b1;
                            end
                        end
                        default:
                        begin
                            emit     = 1'b1;
                            emit_end = q_ctrl.signal_end;
                            q_pop    = 1'b1;
                        end
                    endcase
                end
            end
            BK_DATA:
            begin
                if (out_free)
                begin
                    wr_req     = 1'b1;
                    emit       = 1'b1;
                    q_pop      = 1'b1;
                    state_next = BK_RUN;
                end
            end
            BK_POP_WAIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_valid = 1'b1;
                    state_next = BK_RUN;
                end
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase

        // Store a word or drop it when full
        if (wr_req)
        begin
            if (count_reg == CNT_W'(FIFO_DEPTH))
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                ram_wr_en   = 1'b1;
                wr_ptr_next = ptr_advance(wr_ptr_reg);
                count_next  = count_reg + 1'b1;
            end
        end

        // Load the result register
        if (emit)
        begin
            out_valid_next      = 1'b1;
            out_word_valid_next = emit_valid;
            out_pulse_next      = emit_valid & emit_word[DURATION_BITS];
            out_dur_next        = emit_valid ? OUT_DUR_W'(emit_word[DURATION_BITS-1:0]) : '0;
            out_empty_next      = (count_next == '0);
            out_overflow_next   = dropped_next;
            out_end_next        = emit_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_RUN;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_word_valid_reg <= out_word_valid_next;
        out_pulse_reg      <= out_pulse_next;
        out_dur_reg        <= out_dur_next;
        out_empty_reg      <= out_empty_next;
        out_overflow_reg   <= out_overflow_next;
        out_end_reg        <= out_end_next;
    end

    assign out_valid     = out_valid_reg;
    assign word_valid    = out_word_valid_reg;
    assign is_pulse      = out_pulse_reg;
    assign duration_us   = out_dur_reg;
    assign fifo_empty    = out_empty_reg;
    assign overflow_seen = out_overflow_reg;
    assign signal_end    = out_end_reg;

    // Occupancy never exceeds the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("word count above FIFO depth");

    // Drop flag is sticky
    a_drop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        dropped_reg |=> dropped_reg)
        else $error("drop flag cleared");

    // No store while a read result is pending
    a_no_write_in_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_POP_WAIT) |-> !ram_wr_en)
        else $error("RAM write during pop wait");

    // Second word of a push always has its command at the queue head
    a_data_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DATA) |-> (q_valid && (q_ctrl.kind == CMD_PUSH)))
        else $error("data word state without push command");

    // Empty FIFO has matching pointers
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty FIFO with unequal pointers");

endmodule

FILE: rtl/ir_byte_to_pulse_space_fifo.sv
// Infrared byte stream to pulse/space word FIFO, top level.
// A request passes the command queue and then the result register; a pop that returns a word
// also passes BK_POP_WAIT (RAM read), and a byte that also stores a gap space passes BK_DATA.
// Throughput: one request per cycle into a 2-entry queue while in_stall is low; the back end takes
// a new request only after it leaves BK_POP_WAIT or BK_DATA, and holds while the result stalls.
// Reset: control state, pointers and flags clear at once; gap offset returns to 100000;
// word RAM content is not cleared and needs no clearing pass.
module ir_byte_to_pulse_space_fifo #(
    parameter int FIFO_DEPTH    = 256,
    parameter int DURATION_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        word_valid,
    output logic        is_pulse,
    output logic [23:0] duration_us,
    output logic        fifo_empty,
    output logic        overflow_seen,
    output logic        signal_end
);

    import ibps_pkg::*;

    localparam int WORD_W = DURATION_BITS + 1;

    logic              accept;
    logic              q_full;
    cmd_ctrl_t         f_ctrl;
    logic [WORD_W-1:0] f_space;
    logic [WORD_W-1:0] f_data;
    logic              q_valid;
    logic              q_pop;
    cmd_ctrl_t         q_ctrl;
    logic [WORD_W-1:0] q_space;
    logic [WORD_W-1:0] q_data;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    ibps_front #(
        .DURATION_BITS (DURATION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req_type  (req_type),
        .rx_byte   (rx_byte),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd_ctrl  (f_ctrl),
        .cmd_space (f_space),
        .cmd_data  (f_data)
    );

    ibps_cmd_q #(
        .WORD_W (WORD_W)
    ) u_cmd_q (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_ctrl  (f_ctrl),
        .push_space (f_space),
        .push_data  (f_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_ctrl  (q_ctrl),
        .head_space (q_space),
        .head_data  (q_data)
    );

    ibps_back #(
        .FIFO_DEPTH    (FIFO_DEPTH),
        .DURATION_BITS (DURATION_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_ctrl        (q_ctrl),
        .q_space       (q_space),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .word_valid    (word_valid),
        .is_pulse      (is_pulse),
        .duration_us   (duration_us),
        .fifo_empty    (fifo_empty),
        .overflow_seen (overflow_seen),
        .signal_end    (signal_end)
    );

endmodule

FILE: verif/tb_ir_byte_to_pulse_space_fifo.sv
// Testbench for the infrared byte to pulse/space word FIFO.
// Drives requests and gap offset writes, predicts every result in place and checks it.
// Depends on rtl/ibps_pkg.sv and rtl/ir_byte_to_pulse_space_fifo.sv.
module tb_ir_byte_to_pulse_space_fifo;
    timeunit 1ns;
    timeprecision 1ps;

    import ibps_pkg::*;

    typedef struct packed {
        req_t       kind;
        logic [7:0] data;
    } ir_request_t;

    typedef struct packed {
        logic        word_valid;
        logic        is_pulse;
        logic [23:0] duration;
        logic        empty;
        logic        overflow;
        logic        sig_end;
    } ir_result_t;

    localparam logic [23:0] DUR_MAX = 24'hFFFFFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = REQ_NONE;
    logic [7:0]  rx_byte = 8'd0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [23:0] cfg_data = 24'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        word_valid;
    logic        is_pulse;
    logic [23:0] duration_us;
    logic        fifo_empty;
    logic        overflow_seen;
    logic        signal_end;

    // Predicted block state
    logic [24:0] word_mem [256];
    logic [7:0]  rd_ptr = '0;
    logic [7:0]  wr_ptr = '0;
    logic [8:0]  word_count = '0;
    logic        phase_pulse = 1'b1;
    logic        new_signal = 1'b1;
    logic [23:0] gap_ticks = '0;
    logic        words_dropped = 1'b0;
    logic [23:0] gap_offset = GAP_OFFSET_RESET;

    ir_request_t request_queue[$];
    ir_result_t  predicted_results[$];
    int          requests_sent = 0;
    int          results_seen = 0;
    int          mismatches = 0;

    // Handshake bookkeeping between the sampling and driving edges
    bit req_taken = 1'b0;
    bit res_taken = 1'b0;
    int in_gap_left = 0;
    int in_gap_max = 3;
    int out_wait = 0;
    int out_gap_max = 3;

    ir_byte_to_pulse_space_fifo dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .rx_byte      (rx_byte),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .word_valid   (word_valid),
        .is_pulse     (is_pulse),
        .duration_us  (duration_us),
        .fifo_empty   (fifo_empty),
        .overflow_seen(overflow_seen),
        .signal_end   (signal_end)
    );

    always #1 clk = ~clk;

    // Push one word, or drop it and flag the loss when the FIFO is full
    task automatic store_word(input logic [24:0] word);
        if (word_count == 9'd256)
        begin
            words_dropped = 1'b1;
        end
        else
        begin
            word_mem[wr_ptr] = word;
            wr_ptr++;
            word_count++;
        end
    endtask

    // Advance the predicted state by one request and return its result
    task automatic decode_request(input ir_request_t r, output ir_result_t res);
        logic [24:0] space_sum;
        logic [24:0] word;
        res = '0;
        case (r.kind)
            REQ_BYTE:
            begin
                if (r.data == BYTE_END)
                begin
                    phase_pulse = 1'b1;
                    new_signal = 1'b1;
                    gap_ticks = '0;
                    res.sig_end = 1'b1;
                end
                else if (r.data != BYTE_SKIP)
                begin
                    if (new_signal)
                    begin
                        space_sum = {1'b0, gap_ticks} + {1'b0, gap_offset};
                        if (space_sum[24])
                            space_sum = {1'b0, DUR_MAX};
                        new_signal = 1'b0;
                        gap_ticks = '0;
                        store_word(space_sum);
                    end
                    store_word({phase_pulse, 8'd0, r.data, DUR_ROUND});
                    phase_pulse = !phase_pulse;
                end
            end
            REQ_TICK:
            begin
                if (gap_ticks != DUR_MAX)
                    gap_ticks++;
            end
            REQ_POP:
            begin
                if (word_count != 0)
                begin
                    word = word_mem[rd_ptr];
                    rd_ptr++;
                    word_count--;
                    res.word_valid = 1'b1;
                    res.is_pulse = word[24];
                    res.duration = word[23:0];
                end
            end
            default:
            begin
            end
        endcase
        res.empty = (word_count == 0);
        res.overflow = words_dropped;
    endtask

    // Sample accepted requests and results, predict and check
    always @(posedge clk)
    begin : sample_channels
        ir_result_t exp_res;
        ir_result_t got_res;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                decode_request('{kind: req_t'(req_type), data: rx_byte}, exp_res);
                predicted_results.push_back(exp_res);
                req_taken = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                res_taken = 1'b1;
                got_res.word_valid = word_valid;
                got_res.is_pulse = is_pulse;
                got_res.duration = duration_us;
                got_res.empty = fifo_empty;
                got_res.overflow = overflow_seen;
                got_res.sig_end = signal_end;
                if (predicted_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result valid=%0b pulse=%0b dur=%0d",
                                 word_valid, is_pulse, duration_us);
                end
                else
                begin
                    exp_res = predicted_results.pop_front();
                    if (got_res.word_valid !== exp_res.word_valid ||
                        got_res.is_pulse !== exp_res.is_pulse ||
                        got_res.duration !== exp_res.duration ||
                        got_res.empty !== exp_res.empty ||
                        got_res.overflow !== exp_res.overflow ||
                        got_res.sig_end !== exp_res.sig_end)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: exp valid=%0b pulse=%0b dur=%0d ",
                                     results_seen, exp_res.word_valid, exp_res.is_pulse,
                                     exp_res.duration,
                                     "empty=%0b ovf=%0b end=%0b, ", exp_res.empty,
                                     exp_res.overflow, exp_res.sig_end,
                                     "got valid=%0b pulse=%0b dur=%0d ", got_res.word_valid,
                                     got_res.is_pulse, got_res.duration,
                                     "empty=%0b ovf=%0b end=%0b", got_res.empty,
                                     got_res.overflow, got_res.sig_end);
                    end
                end
            end
        end
    end

    // Present the next request once the current one is taken, after a random gap
    always @(negedge clk)
    begin : drive_requests
        ir_request_t nxt;
        if (rst_n && (!in_valid || req_taken))
        begin
            req_taken = 1'b0;
            if (in_gap_left > 0)
            begin
                in_valid <= 1'b0;
                in_gap_left--;
            end
            else if (request_queue.size() > 0)
            begin
                nxt = request_queue.pop_front();
                in_valid <= 1'b1;
                req_type <= nxt.kind;
                rx_byte <= nxt.data;
                in_gap_left = $urandom_range(0, in_gap_max);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Hold off each result for a random number of cycles
    always @(negedge clk)
    begin : drive_result_stall
        if (rst_n)
        begin
            if (res_taken)
            begin
                res_taken = 1'b0;
                out_wait = $urandom_range(0, out_gap_max);
            end
            out_stall <= (out_wait > 0);
            if (out_valid && out_wait > 0)
                out_wait--;
        end
    end

    task automatic add_request(input req_t kind, input logic [7:0] data);
        request_queue.push_back('{kind: kind, data: data});
        requests_sent++;
    endtask

    // Queue one well-formed signal: gap ticks, data bytes, end byte, pops mixed in
    task automatic add_signal(input int n_bytes, input int max_ticks, input int pop_pct);
        int n_ticks;
        n_ticks = $urandom_range(0, max_ticks);
        repeat (n_ticks)
            add_request(REQ_TICK, 8'($urandom));
        for (int i = 0; i < n_bytes; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                add_request(REQ_BYTE, BYTE_SKIP);
            else
                add_request(REQ_BYTE, 8'($urandom_range(1, 254)));
            if ($urandom_range(0, 99) < pop_pct)
                add_request(REQ_POP, 8'($urandom));
        end
        add_request(REQ_BYTE, BYTE_END);
    endtask

    // Mostly well-formed signals, some random noise requests
    task automatic add_random_mix(input int n_items);
        int target;
        target = requests_sent + n_items;
        while (requests_sent < target)
        begin
            if ($urandom_range(0, 9) < 7)
                add_signal($urandom_range(1, 10), $urandom_range(0, 1) ? 12 : 0, 60);
            else
                add_request(req_t'($urandom_range(0, 3)), 8'($urandom));
        end
    endtask

    // Wait for every result, then let the block settle
    task automatic drain_results();
        wait (results_seen == requests_sent);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_gap_offset(input logic [23:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        gap_offset = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty pop, unused code, ignored bytes, skip, end, first byte spaces
        add_request(REQ_POP, 8'hFF);
        add_request(REQ_NONE, 8'hA5);
        add_request(REQ_TICK, 8'hFF);
        add_request(REQ_TICK, 8'h00);
        add_request(REQ_TICK, 8'h5A);
        add_request(REQ_BYTE, BYTE_SKIP);
        add_request(REQ_BYTE, 8'd1);
        add_request(REQ_BYTE, 8'd254);
        add_request(REQ_BYTE, BYTE_SKIP);
        add_request(REQ_BYTE, 8'd128);
        add_request(REQ_BYTE, BYTE_END);
        add_request(REQ_BYTE, BYTE_END);
        add_request(REQ_TICK, 8'd0);
        add_request(REQ_BYTE, 8'h55);
        add_request(REQ_BYTE, 8'hAA);
        repeat (8)
            add_request(REQ_POP, 8'd0);
        add_request(REQ_BYTE, BYTE_END);
        drain_results();

        // Zero offset: a signal with no ticks gives a zero-length space
        write_gap_offset(24'd0);
        add_signal(3, 0, 0);
        add_random_mix(120);
        drain_results();

        // Largest offset saturates the space word; no idling on either side
        in_gap_max = 0;
        out_gap_max = 0;
        write_gap_offset(DUR_MAX);
        add_request(REQ_TICK, 8'd0);
        add_signal(2, 0, 100);
        add_random_mix(120);
        drain_results();

        // Flood the FIFO past full with no pops, then drain it and run on
        in_gap_max = 3;
        out_gap_max = 3;
        write_gap_offset(24'($urandom));
        repeat (13)
            add_signal(20, 3, 0);
        drain_results();
        in_gap_max = 1;
        repeat (280)
            add_request(REQ_POP, 8'($urandom));
        drain_results();

        in_gap_max = 3;
        write_gap_offset(GAP_OFFSET_RESET);
        add_random_mix(60);
        drain_results();

        repeat (10) @(posedge clk);
        if (mismatches == 0 && predicted_results.size() == 0)
            $display("ir_byte_to_pulse_space_fifo test passed");
        else
            $display("ir_byte_to_pulse_space_fifo test failed");
        $finish;
    end

    // Abort a hung run
    initial
    begin
        #400000;
        $display("ir_byte_to_pulse_space_fifo test failed");
        $finish;
    end

endmodule
